// ===== src/bts_pkg.sv =====
// shared types and constants of the bilinear texture sampler
package bts_pkg;

   localparam int unsigned TEX_MAX_WIDTH  = 256;
   localparam int unsigned TEX_MAX_HEIGHT = 256;

   localparam int CHANNELS = 3;
   localparam int CHAN_W   = 8;
   localparam int DIM_W    = 9;
   localparam int FRAC_W   = 16;
   localparam int FIX_W    = FRAC_W + DIM_W;
   localparam int HORZ_W   = 16;
   localparam int SUM_W    = 24;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [CHANNELS-1:0][CHAN_W-1:0] pixel_type;

   typedef struct packed {
      logic       load;
      logic [1:0] tap;
      logic       vert;
   } blend_ctrl_type;

   localparam logic [1:0] CSR_TEX_WIDTH       = 2'd0;
   localparam logic [1:0] CSR_TEX_HEIGHT      = 2'd1;
   localparam logic [1:0] CSR_FILTER_MODE     = 2'd2;
   localparam logic [1:0] CSR_TEXTURE_PRESENT = 2'd3;

   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   localparam logic FILTER_NEAREST  = 1'b0;
   localparam logic FILTER_BILINEAR = 1'b1;

   localparam logic [1:0] TAP_00 = 2'd0;
   localparam logic [1:0] TAP_10 = 2'd1;
   localparam logic [1:0] TAP_01 = 2'd2;
   localparam logic [1:0] TAP_11 = 2'd3;

   localparam pixel_type FALLBACK_COLOR = {8'd128, 8'd89, 8'd51};

endpackage

// ===== src/bts_blend.sv =====
// per-channel horizontal and vertical blend lanes of the sampler
module bts_blend
   import bts_pkg::*;
(
   input  logic           clock,
   input  blend_ctrl_type ctrl,
   input  pixel_type      texel,
   input  chan_type       tx,
   input  chan_type       ty,
   output pixel_type      pix
);

   logic [DIM_W-1:0]  wx0;
   logic [DIM_W-1:0]  wy0;
   logic [HORZ_W-1:0] hacc_ff [CHANNELS];
   logic [HORZ_W-1:0] h0_ff   [CHANNELS];
   logic [HORZ_W-1:0] h1_ff   [CHANNELS];
   logic [SUM_W-1:0]  sacc_ff [CHANNELS];
   logic [SUM_W-1:0]  sum     [CHANNELS];

   assign wx0 = 9'd256 - {1'b0, tx};
   assign wy0 = 9'd256 - {1'b0, ty};

   always_ff @(posedge clock) begin
      for (int c = 0; c < CHANNELS; c++) begin
         if (ctrl.load) begin
            case (ctrl.tap)
               TAP_00, TAP_01: begin
                  hacc_ff[c] <= HORZ_W'(texel[c]) * HORZ_W'(wx0);
               end
               TAP_10: begin
                  h0_ff[c] <= hacc_ff[c] + HORZ_W'(texel[c]) * HORZ_W'(tx);
               end
               TAP_11: begin
                  h1_ff[c] <= hacc_ff[c] + HORZ_W'(texel[c]) * HORZ_W'(tx);
               end
               default: begin
                  hacc_ff[c] <= hacc_ff[c];
               end
            endcase
         end
         if (ctrl.vert) begin
            sacc_ff[c] <= SUM_W'(h0_ff[c]) * SUM_W'(wy0);
         end
      end
   end

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         sum[c] = sacc_ff[c] + SUM_W'(h1_ff[c]) * SUM_W'(ty) + SUM_W'(32768);
         pix[c] = sum[c][SUM_W-1 -: CHAN_W];
      end
   end

endmodule

// ===== src/bilinear_texture_sampler.sv =====
// top level of the texture sampler: csr block, texel memory and sample sequencer
// A write transaction (req_mode 0) stores one texel in the cycle it is accepted and
// gives no result; busy stays low. A sample transaction gives one result on the rsp_
// ports for a single cycle marked by rsp_strobe, which the receiver must take as it
// comes. With no texture present the result appears in the cycle after accept and busy
// stays low. Nearest mode holds busy in ADDR, READ and DRAIN, the result following in
// the next cycle; bilinear mode holds busy also in VERT0 and VERT1 after DRAIN, READ
// fetching the four neighbouring texels one per cycle through the memory's single port.
// A new transaction may be accepted in the cycle its predecessor's result shows.
// The texel memory is not cleared by reset; sample only texels already written.
module bilinear_texture_sampler
   import bts_pkg::*;
#(
   parameter int unsigned MAX_WIDTH  = TEX_MAX_WIDTH,
   parameter int unsigned MAX_HEIGHT = TEX_MAX_HEIGHT
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_mode,
   input  logic [7:0]           req_texel_x,
   input  logic [7:0]           req_texel_y,
   input  logic [CHAN_W-1:0]    req_in_red,
   input  logic [CHAN_W-1:0]    req_in_green,
   input  logic [CHAN_W-1:0]    req_in_blue,
   input  logic [FRAC_W-1:0]    req_u_frac,
   input  logic [FRAC_W-1:0]    req_v_frac,
   output logic                 rsp_strobe,
   output logic [CHAN_W-1:0]    rsp_out_red,
   output logic [CHAN_W-1:0]    rsp_out_green,
   output logic [CHAN_W-1:0]    rsp_out_blue,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [DIM_W-1:0]     csr_data
);

   localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADDR,
      ST_READ,
      ST_DRAIN,
      ST_VERT0,
      ST_VERT1
   } state_type;

   state_type state_ff;

   logic [DIM_W-1:0] tex_width_ff;
   logic [DIM_W-1:0] tex_height_ff;
   logic             filter_mode_ff;
   logic             texture_present_ff;

   logic [DIM_W-1:0] w_eff;
   logic [DIM_W-1:0] h_eff;
   logic [FIX_W-1:0] fx_ff;
   logic [FIX_W-1:0] fy_ff;
   logic [DIM_W-1:0] x0_in;
   logic [DIM_W-1:0] y0_in;
   logic [DIM_W-1:0] x0_ff;
   logic [DIM_W-1:0] x1_ff;
   logic [DIM_W-1:0] y0_ff;
   logic [DIM_W-1:0] y1_ff;
   logic [1:0]       rk_ff;
   logic             dv_ff;
   logic [1:0]       dk_ff;

   logic             accept;
   logic             wr_en;
   logic             rd_en;
   logic [DIM_W-1:0] rd_x;
   logic [DIM_W-1:0] rd_y;
   logic [AW-1:0]    rd_addr;
   logic [AW-1:0]    wr_addr;
   logic [AW-1:0]    mem_addr;
   pixel_type        wr_data;
   pixel_type        rdata_ff;
   pixel_type        mem [DEPTH];

   blend_ctrl_type   bctrl;
   pixel_type        blend_pix;
   pixel_type        rsp_pix_ff;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff       <= 9'd256;
         tex_height_ff      <= 9'd256;
         filter_mode_ff     <= FILTER_BILINEAR;
         texture_present_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TEX_WIDTH:       tex_width_ff       <= csr_data;
            CSR_TEX_HEIGHT:      tex_height_ff      <= csr_data;
            CSR_FILTER_MODE:     filter_mode_ff     <= csr_data[0];
            CSR_TEXTURE_PRESENT: texture_present_ff <= csr_data[0];
            default:             tex_width_ff       <= tex_width_ff;
         endcase
      end
   end

   always_comb begin
      if (tex_width_ff == '0) begin
         w_eff = 9'd1;
      end else if (int'(tex_width_ff) > int'(MAX_WIDTH)) begin
         w_eff = DIM_W'(MAX_WIDTH);
      end else begin
         w_eff = tex_width_ff;
      end
      if (tex_height_ff == '0) begin
         h_eff = 9'd1;
      end else if (int'(tex_height_ff) > int'(MAX_HEIGHT)) begin
         h_eff = DIM_W'(MAX_HEIGHT);
      end else begin
         h_eff = tex_height_ff;
      end
      x0_in = fx_ff[FIX_W-1 -: DIM_W];
      y0_in = fy_ff[FIX_W-1 -: DIM_W];
      if (x0_in > w_eff - 9'd1) begin
         x0_in = w_eff - 9'd1;
      end
      if (y0_in > h_eff - 9'd1) begin
         y0_in = h_eff - 9'd1;
      end
   end

   // texel memory, single port
   assign wr_en   = accept && (req_mode == MODE_WRITE)
                    && (int'(req_texel_x) < int'(MAX_WIDTH))
                    && (int'(req_texel_y) < int'(MAX_HEIGHT));
   assign wr_addr = AW'(req_texel_y) * ROW_STRIDE + AW'(req_texel_x);
   assign wr_data = {req_in_red, req_in_green, req_in_blue};

   assign rd_en    = (state_ff == ST_READ);
   assign rd_x     = rk_ff[0] ? x1_ff : x0_ff;
   assign rd_y     = rk_ff[1] ? y1_ff : y0_ff;
   assign rd_addr  = AW'(rd_y) * ROW_STRIDE + AW'(rd_x);
   assign mem_addr = rd_en ? rd_addr : wr_addr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[mem_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= 1'b0;
      end else begin
         dv_ff <= rd_en;
      end
      dk_ff <= rk_ff;
   end

   assign bctrl.load = dv_ff;
   assign bctrl.tap  = dk_ff;
   assign bctrl.vert = (state_ff == ST_VERT0);

   bts_blend u_blend (
      .clock (clock),
      .ctrl  (bctrl),
      .texel (rdata_ff),
      .tx    (fx_ff[FRAC_W-1 -: CHAN_W]),
      .ty    (fy_ff[FRAC_W-1 -: CHAN_W]),
      .pix   (blend_pix)
   );

   // sample sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rsp_strobe <= 1'b0;
         rk_ff      <= '0;
      end else begin
         rsp_strobe <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept && req_mode == MODE_SAMPLE) begin
                  if (!texture_present_ff) begin
                     rsp_strobe <= 1'b1;
                     rsp_pix_ff <= FALLBACK_COLOR;
                  end else begin
                     fx_ff    <= FIX_W'(req_u_frac) * FIX_W'(w_eff - 9'd1);
                     fy_ff    <= FIX_W'(req_v_frac) * FIX_W'(h_eff - 9'd1);
                     state_ff <= ST_ADDR;
                  end
               end
            end
            ST_ADDR: begin
               x0_ff    <= x0_in;
               y0_ff    <= y0_in;
               x1_ff    <= (x0_in + 9'd1 == w_eff) ? '0 : x0_in + 9'd1;
               y1_ff    <= (y0_in + 9'd1 == h_eff) ? '0 : y0_in + 9'd1;
               rk_ff    <= TAP_00;
               state_ff <= ST_READ;
            end
            ST_READ: begin
               rk_ff <= rk_ff + 2'd1;
               if (filter_mode_ff == FILTER_NEAREST || rk_ff == TAP_11) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (filter_mode_ff == FILTER_NEAREST) begin
                  rsp_strobe <= 1'b1;
                  rsp_pix_ff <= rdata_ff;
                  state_ff   <= ST_IDLE;
               end else begin
                  state_ff <= ST_VERT0;
               end
            end
            ST_VERT0: begin
               state_ff <= ST_VERT1;
            end
            ST_VERT1: begin
               rsp_strobe <= 1'b1;
               rsp_pix_ff <= blend_pix;
               state_ff   <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_out_red   = rsp_pix_ff[2];
   assign rsp_out_green = rsp_pix_ff[1];
   assign rsp_out_blue  = rsp_pix_ff[0];

endmodule

// ===== test/tb_bilinear_texture_sampler.sv =====
// testbench of the bilinear texture sampler: directed and random texel writes and samples
`timescale 1ns / 100ps

module tb_bilinear_texture_sampler;
   import bts_pkg::*;

   typedef struct {
      logic              mode;
      logic [7:0]        texel_x;
      logic [7:0]        texel_y;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [FRAC_W-1:0] u_frac;
      logic [FRAC_W-1:0] v_frac;
   } sampler_request_type;

   class sampler_scoreboard;
      pixel_type   texel_mem [TEX_MAX_WIDTH*TEX_MAX_HEIGHT];
      bit          texel_valid [TEX_MAX_WIDTH*TEX_MAX_HEIGHT];
      int unsigned width_csr   = 256;
      int unsigned height_csr  = 256;
      bit          filter_csr  = FILTER_BILINEAR;
      bit          present_csr = 1'b0;
      pixel_type   expected_colors [$];
      int unsigned errors;

      function void set_register(input logic [1:0] idx, input logic [DIM_W-1:0] data);
         case (idx)
            CSR_TEX_WIDTH: begin
               width_csr = 32'(data);
            end
            CSR_TEX_HEIGHT: begin
               height_csr = 32'(data);
            end
            CSR_FILTER_MODE: begin
               filter_csr = data[0];
            end
            CSR_TEXTURE_PRESENT: begin
               present_csr = data[0];
            end
            default: begin
            end
         endcase
      endfunction

      function int unsigned active_dim(input int unsigned d, input int unsigned maxd);
         if (d == 0) begin
            return 1;
         end
         if (d > maxd) begin
            return maxd;
         end
         return d;
      endfunction

      // texel footprint and weights of one sample
      function void locate(input logic [FRAC_W-1:0] u, input logic [FRAC_W-1:0] v,
                           output int unsigned x0, output int unsigned y0,
                           output int unsigned x1, output int unsigned y1,
                           output int unsigned tx, output int unsigned ty);
         int unsigned w;
         int unsigned h;
         int unsigned fx;
         int unsigned fy;
         w  = active_dim(width_csr, TEX_MAX_WIDTH);
         h  = active_dim(height_csr, TEX_MAX_HEIGHT);
         fx = u * (w - 1);
         fy = v * (h - 1);
         x0 = fx >> 16;
         y0 = fy >> 16;
         if (x0 > w - 1) begin
            x0 = w - 1;
         end
         if (y0 > h - 1) begin
            y0 = h - 1;
         end
         x1 = (x0 + 1) % w;
         y1 = (y0 + 1) % h;
         tx = (fx >> 8) & 8'hFF;
         ty = (fy >> 8) & 8'hFF;
      endfunction

      function pixel_type filtered_color(input logic [FRAC_W-1:0] u,
                                         input logic [FRAC_W-1:0] v);
         int unsigned x0;
         int unsigned y0;
         int unsigned x1;
         int unsigned y1;
         int unsigned tx;
         int unsigned ty;
         int unsigned h0;
         int unsigned h1;
         int unsigned s;
         pixel_type   c00;
         pixel_type   c10;
         pixel_type   c01;
         pixel_type   c11;
         pixel_type   color;
         if (!present_csr) begin
            return {8'd128, 8'd89, 8'd51};
         end
         locate(u, v, x0, y0, x1, y1, tx, ty);
         c00 = texel_mem[y0*TEX_MAX_WIDTH + x0];
         if (filter_csr == FILTER_NEAREST) begin
            return c00;
         end
         c10 = texel_mem[y0*TEX_MAX_WIDTH + x1];
         c01 = texel_mem[y1*TEX_MAX_WIDTH + x0];
         c11 = texel_mem[y1*TEX_MAX_WIDTH + x1];
         for (int k = 0; k < CHANNELS; k++) begin
            h0 = c00[k] * (256 - tx) + c10[k] * tx;
            h1 = c01[k] * (256 - tx) + c11[k] * tx;
            s  = h0 * (256 - ty) + h1 * ty;
            color[k] = CHAN_W'((s + 32768) >> 16);
         end
         return color;
      endfunction

      function void note_request(input sampler_request_type rq);
         int unsigned addr;
         if (rq.mode == MODE_WRITE) begin
            addr = rq.texel_y * TEX_MAX_WIDTH + rq.texel_x;
            texel_mem[addr]   = {rq.red, rq.green, rq.blue};
            texel_valid[addr] = 1'b1;
         end else begin
            expected_colors.push_back(filtered_color(rq.u_frac, rq.v_frac));
         end
      endfunction

      function void check_color(input pixel_type got);
         pixel_type want;
         bit        bad;
         if (expected_colors.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("%0t: result with no sample pending: red %0d green %0d blue %0d",
                        $realtime, got[2], got[1], got[0]);
            end
            return;
         end
         want = expected_colors.pop_front();
         bad  = 1'b0;
         for (int k = 0; k < CHANNELS; k++) begin
            if (got[k] !== want[k]) begin
               bad = 1'b1;
            end
         end
         if (bad) begin
            errors++;
            if (errors <= 10) begin
               $display("%0t: color mismatch: red %0d/%0d green %0d/%0d blue %0d/%0d (exp/act)",
                        $realtime, want[2], got[2], want[1], got[1], want[0], got[0]);
            end
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_mode = MODE_WRITE;
   logic [7:0]        req_texel_x = '0;
   logic [7:0]        req_texel_y = '0;
   logic [CHAN_W-1:0] req_in_red = '0;
   logic [CHAN_W-1:0] req_in_green = '0;
   logic [CHAN_W-1:0] req_in_blue = '0;
   logic [FRAC_W-1:0] req_u_frac = '0;
   logic [FRAC_W-1:0] req_v_frac = '0;
   logic              rsp_strobe;
   logic [CHAN_W-1:0] rsp_out_red;
   logic [CHAN_W-1:0] rsp_out_green;
   logic [CHAN_W-1:0] rsp_out_blue;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index = CSR_TEX_WIDTH;
   logic [DIM_W-1:0]  csr_data = '0;

   sampler_scoreboard sb = new;
   int unsigned       idle_pct = 24;
   int unsigned       items_sent;

   bilinear_texture_sampler dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_texel_x(req_texel_x),
      .req_texel_y(req_texel_y),
      .req_in_red(req_in_red),
      .req_in_green(req_in_green),
      .req_in_blue(req_in_blue),
      .req_u_frac(req_u_frac),
      .req_v_frac(req_v_frac),
      .rsp_strobe(rsp_strobe),
      .rsp_out_red(rsp_out_red),
      .rsp_out_green(rsp_out_green),
      .rsp_out_blue(rsp_out_blue),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         sb.check_color({rsp_out_red, rsp_out_green, rsp_out_blue});
      end
   end

   function automatic sampler_request_type random_fields();
      sampler_request_type rq;
      rq.mode    = 1'($urandom_range(0, 1));
      rq.texel_x = 8'($urandom_range(0, 255));
      rq.texel_y = 8'($urandom_range(0, 255));
      rq.red     = CHAN_W'($urandom_range(0, 255));
      rq.green   = CHAN_W'($urandom_range(0, 255));
      rq.blue    = CHAN_W'($urandom_range(0, 255));
      rq.u_frac  = FRAC_W'($urandom_range(0, 65535));
      rq.v_frac  = FRAC_W'($urandom_range(0, 65535));
      return rq;
   endfunction

   function automatic logic [FRAC_W-1:0] pick_frac();
      case ($urandom_range(0, 9))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         default: begin
            return FRAC_W'($urandom_range(0, 65535));
         end
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] pick_dim();
      case ($urandom_range(0, 9))
         0: begin
            return 9'd1;
         end
         1: begin
            return 9'd2;
         end
         2: begin
            return 9'd256;
         end
         3: begin
            return 9'd0;
         end
         4: begin
            return DIM_W'($urandom_range(257, 511));
         end
         5, 6: begin
            return DIM_W'($urandom_range(1, 16));
         end
         default: begin
            return DIM_W'($urandom_range(1, 256));
         end
      endcase
   endfunction

   task automatic send_request(input sampler_request_type rq);
      req_mode     <= rq.mode;
      req_texel_x  <= rq.texel_x;
      req_texel_y  <= rq.texel_y;
      req_in_red   <= rq.red;
      req_in_green <= rq.green;
      req_in_blue  <= rq.blue;
      req_u_frac   <= rq.u_frac;
      req_v_frac   <= rq.v_frac;
      start        <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_request(rq);
      items_sent++;
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
   endtask

   task automatic write_texel(input int unsigned x, input int unsigned y,
                              input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      sampler_request_type rq;
      rq         = random_fields();
      rq.mode    = MODE_WRITE;
      rq.texel_x = 8'(x);
      rq.texel_y = 8'(y);
      rq.red     = r;
      rq.green   = g;
      rq.blue    = b;
      send_request(rq);
   endtask

   task automatic fill_texel(input int unsigned x, input int unsigned y, input bit refresh);
      if (refresh || !sb.texel_valid[y*TEX_MAX_WIDTH + x]) begin
         write_texel(x, y, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
      end
   endtask

   // when a texture is present, writes whatever the footprint lacks (or at random all of it), then samples
   task automatic sample_at(input logic [FRAC_W-1:0] u, input logic [FRAC_W-1:0] v);
      sampler_request_type rq;
      int unsigned         x0;
      int unsigned         y0;
      int unsigned         x1;
      int unsigned         y1;
      int unsigned         tx;
      int unsigned         ty;
      bit                  refresh;
      refresh = ($urandom_range(0, 99) < 30);
      if (sb.present_csr) begin
         sb.locate(u, v, x0, y0, x1, y1, tx, ty);
         fill_texel(x0, y0, refresh);
         if (sb.filter_csr == FILTER_BILINEAR) begin
            fill_texel(x1, y0, refresh);
            fill_texel(x0, y1, refresh);
            fill_texel(x1, y1, refresh);
         end
      end
      rq        = random_fields();
      rq.mode   = MODE_SAMPLE;
      rq.u_frac = u;
      rq.v_frac = v;
      send_request(rq);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [DIM_W-1:0] data);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.expected_colors.size() != 0) begin
         @(posedge clock);
      end
      repeat (12) @(posedge clock);
   endtask

   task automatic configure_random();
      write_register(CSR_TEX_WIDTH, pick_dim());
      write_register(CSR_TEX_HEIGHT, pick_dim());
      write_register(CSR_FILTER_MODE,
                     {8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))});
      write_register(CSR_TEXTURE_PRESENT,
                     {8'($urandom_range(0, 255)), 1'($urandom_range(0, 99) < 85)});
   endtask

   initial begin
      int unsigned idle_levels [3];
      int unsigned phase_end;
      sampler_request_type rq;
      idle_levels = '{24, 80, 0};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fallback color before any texture
      sample_at('0, '0);
      sample_at('1, '1);
      write_texel(0, 0, 8'h00, 8'h00, 8'h00);
      write_texel(255, 255, 8'hFF, 8'hFF, 8'hFF);
      drain();
      write_register(CSR_TEXTURE_PRESENT, 9'd1);
      sample_at('0, '0);
      sample_at('1, '1);
      sample_at('1, '0);
      drain();
      write_register(CSR_FILTER_MODE, DIM_W'(FILTER_NEAREST));
      sample_at('1, '1);
      sample_at('0, '0);
      drain();
      // zero size acts as one texel, so the neighbor wraps onto itself
      write_register(CSR_TEX_WIDTH, 9'd0);
      write_register(CSR_TEX_HEIGHT, 9'd1);
      write_register(CSR_FILTER_MODE, DIM_W'(FILTER_BILINEAR));
      sample_at(16'h8000, 16'h8000);
      drain();
      // oversize clamps to the full store
      write_register(CSR_TEX_WIDTH, 9'd511);
      write_register(CSR_TEX_HEIGHT, 9'd300);
      sample_at('1, 16'h8000);

      for (int r = 0; r < 3; r++) begin
         idle_pct = idle_levels[r];
         for (int p = 0; p < 4; p++) begin
            drain();
            configure_random();
            phase_end = items_sent + 108;
            while (items_sent < phase_end) begin
               if ($urandom_range(0, 99) < 15) begin
                  rq      = random_fields();
                  rq.mode = MODE_WRITE;
                  send_request(rq);
               end else begin
                  sample_at(pick_frac(), pick_frac());
               end
            end
         end
      end

      drain();
      if (sb.errors == 0 && sb.expected_colors.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
